// ----- hw/rtl/tracked_body_chooser_assert.svh -----
// ----------------------------------------------------------------------------
// tracked_body_chooser_assert.svh
// Assertion macros shared by the chooser's checker.
// ----------------------------------------------------------------------------
`ifndef TRACKED_BODY_CHOOSER_ASSERT_SVH
`define TRACKED_BODY_CHOOSER_ASSERT_SVH

// ante implies cons after the ##n delay, outside reset
`define TBC_ASSERT_DELAY(lbl, clk, rst_n, ante, n, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> ##n (cons)) else $error(msg);

// ante implies cons in the next cycle, reset included
`define TBC_ASSERT_NEXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/tbc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbc_pkg
// Types and constants of the tracked body chooser.
// ----------------------------------------------------------------------------
package tbc_pkg;

    localparam int MODE_W     = 3;
    localparam int ID_W       = 32;
    localparam int DEPTH_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [MODE_W-1:0] MODE_NONE        = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CLOSEST_ONE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CLOSEST_TWO = 3'd2;
    localparam logic [MODE_W-1:0] MODE_STICKY_ONE  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_STICKY_TWO  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING = 2'd1;

    localparam logic [DEPTH_W-1:0] CEILING_RESET = 16'd32007;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [DEPTH_W-1:0] ceiling;
    } t_cfg;

    typedef struct packed {
        logic               tracked;
        logic [ID_W-1:0]    id;
        logic [DEPTH_W-1:0] depth;
        logic               last;
    } t_slot;

endpackage

// ----- hw/rtl/tbc_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbc_cfg
// Configuration registers: chooser mode and depth ceiling.
// ----------------------------------------------------------------------------
module tbc_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [tbc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tbc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                             o_cfg_ready,
    output tbc_pkg::t_cfg                    o_cfg
);

    tbc_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode    <= tbc_pkg::MODE_NONE;
            r_cfg.ceiling <= tbc_pkg::CEILING_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tbc_pkg::CFG_MODE: begin
                    r_cfg.mode <= i_cfg_data[tbc_pkg::MODE_W-1:0];
                end
                tbc_pkg::CFG_CEILING: begin
                    r_cfg.ceiling <= i_cfg_data[tbc_pkg::DEPTH_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ----- hw/rtl/tbc_pick.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbc_pick
// Sticky choice: keep stored IDs still tracked, fill empty places in slot order.
// ----------------------------------------------------------------------------
module tbc_pick #(
    parameter int SLOTS = 6
) (
    input  logic [tbc_pkg::ID_W-1:0] i_ids [SLOTS],
    input  logic [SLOTS-1:0]         i_trk,
    input  logic [tbc_pkg::ID_W-1:0] i_kept0,
    input  logic [tbc_pkg::ID_W-1:0] i_kept1,
    output logic [tbc_pkg::ID_W-1:0] o_pick0,
    output logic [tbc_pkg::ID_W-1:0] o_pick1
);

    logic                     m0;
    logic                     m1;
    logic [tbc_pkg::ID_W-1:0] p0;
    logic [tbc_pkg::ID_W-1:0] p1;

    always_comb begin
        m0 = 1'b0;
        m1 = 1'b0;
        for (int s = 0; s < SLOTS; s++) begin
            m0 = m0 | (i_trk[s] & (i_ids[s] == i_kept0));
            m1 = m1 | (i_trk[s] & (i_ids[s] == i_kept1));
        end
        p0 = m0 ? i_kept0 : '0;
        p1 = m1 ? i_kept1 : '0;
        // ID 0 marks an empty place
        for (int s = 0; s < SLOTS; s++) begin
            if (i_trk[s] && !((p0 != '0) && (p1 != '0))) begin
                if ((p0 == '0) && (i_ids[s] != p1)) begin
                    p0 = i_ids[s];
                end else if ((p1 == '0) && (i_ids[s] != p0)) begin
                    p1 = i_ids[s];
                end
            end
        end
    end

    assign o_pick0 = p0;
    assign o_pick1 = p1;

endmodule

// ----- hw/rtl/tbc_frame.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbc_frame
// Frame store, running nearest-two search and registered frame-end result.
// ----------------------------------------------------------------------------
module tbc_frame #(
    parameter int SLOTS = 6
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  tbc_pkg::t_slot           i_slot,
    input  tbc_pkg::t_cfg            i_cfg,
    output logic                     o_strobe,
    output logic [tbc_pkg::ID_W-1:0] o_first_id,
    output logic [tbc_pkg::ID_W-1:0] o_second_id
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    logic [CNT_W-1:0]            r_count;
    logic [SLOTS-1:0]            r_trk;
    logic [tbc_pkg::ID_W-1:0]    r_ids [SLOTS];
    logic [tbc_pkg::DEPTH_W-1:0] r_nd0, r_nd1;
    logic [tbc_pkg::ID_W-1:0]    r_ni0, r_ni1;
    logic [tbc_pkg::ID_W-1:0]    r_kept0, r_kept1;
    logic                        r_strobe;
    logic [tbc_pkg::ID_W-1:0]    r_first, r_second;

    logic [CNT_W-1:0]            n_count;
    logic [SLOTS-1:0]            v_trk;
    logic [SLOTS-1:0]            n_trk;
    logic [tbc_pkg::ID_W-1:0]    n_ids [SLOTS];
    logic [tbc_pkg::DEPTH_W-1:0] b_d0, b_d1;
    logic [tbc_pkg::ID_W-1:0]    b_i0, b_i1;
    logic [tbc_pkg::DEPTH_W-1:0] n_nd0, n_nd1;
    logic [tbc_pkg::ID_W-1:0]    n_ni0, n_ni1;
    logic [tbc_pkg::ID_W-1:0]    n_kept0, n_kept1;
    logic [tbc_pkg::ID_W-1:0]    n_first, n_second;
    logic [tbc_pkg::ID_W-1:0]    pick0, pick1;
    logic                        in_range;
    logic                        frame_start;

    assign in_range    = r_count < CNT_W'(SLOTS);
    assign frame_start = r_count == '0;

    always_comb begin
        b_d0 = frame_start ? i_cfg.ceiling : r_nd0;
        b_d1 = frame_start ? i_cfg.ceiling : r_nd1;
        b_i0 = frame_start ? '0 : r_ni0;
        b_i1 = frame_start ? '0 : r_ni1;
        n_nd0 = b_d0;
        n_nd1 = b_d1;
        n_ni0 = b_i0;
        n_ni1 = b_i1;
        n_ids = r_ids;
        v_trk = r_trk;
        n_count = r_count;
        if (in_range) begin
            n_ids[r_count[IDX_W-1:0]] = i_slot.id;
            v_trk[r_count[IDX_W-1:0]] = i_slot.tracked;
            n_count = r_count + CNT_W'(1);
            if (i_slot.tracked) begin
                // strict less-than: first of equal depths wins
                if (i_slot.depth < b_d0) begin
                    n_nd1 = b_d0;
                    n_ni1 = b_i0;
                    n_nd0 = i_slot.depth;
                    n_ni0 = i_slot.id;
                end else if (i_slot.depth < b_d1) begin
                    n_nd1 = i_slot.depth;
                    n_ni1 = i_slot.id;
                end
            end
        end
        n_trk = v_trk;
        if (i_slot.last) begin
            n_trk   = '0;
            n_count = '0;
        end
    end

    tbc_pick #(
        .SLOTS (SLOTS)
    ) u_pick (
        .i_ids   (n_ids),
        .i_trk   (v_trk),
        .i_kept0 (r_kept0),
        .i_kept1 (r_kept1),
        .o_pick0 (pick0),
        .o_pick1 (pick1)
    );

    always_comb begin
        n_first  = '0;
        n_second = '0;
        n_kept0  = r_kept0;
        n_kept1  = r_kept1;
        case (i_cfg.mode)
            tbc_pkg::MODE_CLOSEST_ONE: begin
                n_first = n_ni0;
            end
            tbc_pkg::MODE_CLOSEST_TWO: begin
                n_first  = n_ni0;
                n_second = n_ni1;
            end
            tbc_pkg::MODE_STICKY_ONE: begin
                n_first = pick0;
                n_kept0 = pick0;
                n_kept1 = pick1;
            end
            tbc_pkg::MODE_STICKY_TWO: begin
                n_first  = pick0;
                n_second = pick1;
                n_kept0  = pick0;
                n_kept1  = pick1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_trk    <= '0;
            r_kept0  <= '0;
            r_kept1  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_valid & i_slot.last;
            if (i_valid) begin
                r_count <= n_count;
                r_trk   <= n_trk;
                if (i_slot.last) begin
                    r_kept0 <= n_kept0;
                    r_kept1 <= n_kept1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_ids <= n_ids;
            r_nd0 <= n_nd0;
            r_nd1 <= n_nd1;
            r_ni0 <= n_ni0;
            r_ni1 <= n_ni1;
            if (i_slot.last) begin
                r_first  <= n_first;
                r_second <= n_second;
            end
        end
    end

    assign o_strobe    = r_strobe;
    assign o_first_id  = r_first;
    assign o_second_id = r_second;

endmodule

// ----- hw/rtl/tracked_body_chooser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tracked_body_chooser
// Chooses up to two tracked body IDs per frame, closest or sticky.
// ----------------------------------------------------------------------------
// Usage:
//   Slot words enter on start when busy is low: tracked flag, ID, depth and
//   a last-slot mark. One word may enter every clock cycle; throughput is one
//   slot per cycle, set by the single pass through the slot register and the
//   frame logic.
//   The word with last_slot set gives one result via the slot register and
//   the result registers: o_strobe is high for one cycle with o_first_id and
//   o_second_id. Other words produce nothing. The receiver cannot stall; the
//   IDs hold until the next result, but only the strobe marks them.
//   Configuration: i_cfg_valid/o_cfg_ready with i_cfg_index (0 mode,
//   1 depth ceiling) and i_cfg_data; write only while no frame is in flight.
//   Reset (synchronous, active low) sets mode none, ceiling 32007, clears the
//   frame and stored IDs; busy stays high until the init register sets after reset.
// ----------------------------------------------------------------------------
module tracked_body_chooser #(
    parameter int SLOTS = 6
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_is_tracked,
    input  logic [tbc_pkg::ID_W-1:0]       i_body_id,
    input  logic [tbc_pkg::DEPTH_W-1:0]    i_body_depth,
    input  logic                           i_last_slot,
    output logic                           o_strobe,
    output logic [tbc_pkg::ID_W-1:0]       o_first_id,
    output logic [tbc_pkg::ID_W-1:0]       o_second_id,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tbc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tbc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic           r_init;
    logic           r_in_valid;
    tbc_pkg::t_slot r_slot;
    tbc_pkg::t_cfg  cfg;
    logic           accept;

    assign busy   = ~r_init;
    assign accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init     <= 1'b0;
            r_in_valid <= 1'b0;
        end else begin
            r_init     <= 1'b1;
            r_in_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_slot.tracked <= i_is_tracked;
            r_slot.id      <= i_body_id;
            r_slot.depth   <= i_body_depth;
            r_slot.last    <= i_last_slot;
        end
    end

    tbc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    tbc_frame #(
        .SLOTS (SLOTS)
    ) u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_in_valid),
        .i_slot      (r_slot),
        .i_cfg       (cfg),
        .o_strobe    (o_strobe),
        .o_first_id  (o_first_id),
        .o_second_id (o_second_id)
    );

endmodule

// ----- hw/rtl/tbc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbc_checker
// Port-level checks on the chooser's result timing and reset behaviour.
// ----------------------------------------------------------------------------
`include "tracked_body_chooser_assert.svh"

module tbc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_last_slot,
    input logic o_strobe
);

    `TBC_ASSERT_DELAY(a_last_gives_result, i_clk, i_rst_n, start && !busy && i_last_slot, 2, o_strobe, "last slot word gave no result")
    `TBC_ASSERT_DELAY(a_mid_no_result, i_clk, i_rst_n, start && !busy && !i_last_slot, 2, !o_strobe, "result from a word that is not last")
    `TBC_ASSERT_NEXT(a_reset_no_result, i_clk, !i_rst_n, !o_strobe, "result strobe after reset")
    `TBC_ASSERT_NEXT(a_reset_busy, i_clk, !i_rst_n, busy, "busy low straight after reset")

endmodule

bind tracked_body_chooser tbc_checker u_tbc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_last_slot (i_last_slot),
    .o_strobe    (o_strobe)
);

// ----- dv/tb_tracked_body_chooser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tracked_body_chooser
// Self-checking bench for the tracked body chooser.
// A short table of slot words and register writes opens the run. Random frames
// follow in phases, most opening with a new mode or ceiling. Each accepted
// word goes through a local model of the nearest and sticky choice. Every
// strobed ID pair is compared with the oldest expected pair (table or model).
// ----------------------------------------------------------------------------
module tb_tracked_body_chooser;

    localparam int SLOTS        = 6;
    localparam int POOL         = 6;
    localparam int RANDOM_WORDS = 1150;
    localparam int PLAN_ROWS    = 32;
    localparam int SHOW_FAILS   = 10;
    localparam int MODES        = 1 << tbc_pkg::MODE_W;

    localparam logic [tbc_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [tbc_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam logic [tbc_pkg::MODE_W-1:0]    MODE_SPARE  = 3'd7;

    typedef struct packed {
        logic [tbc_pkg::ID_W-1:0] first;
        logic [tbc_pkg::ID_W-1:0] second;
    } t_pick_pair;

    typedef struct packed {
        logic                           is_cfg;
        logic [tbc_pkg::CFG_IDX_W-1:0]  idx;
        logic [tbc_pkg::CFG_DATA_W-1:0] data;
        tbc_pkg::t_slot                 slot;
        logic                           typed;
        t_pick_pair                     want;
    } t_plan_row;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           start = 1'b0;
    logic                           busy;
    logic                           i_is_tracked = 1'b0;
    logic [tbc_pkg::ID_W-1:0]       i_body_id = '0;
    logic [tbc_pkg::DEPTH_W-1:0]    i_body_depth = '0;
    logic                           i_last_slot = 1'b0;
    logic                           o_strobe;
    logic [tbc_pkg::ID_W-1:0]       o_first_id;
    logic [tbc_pkg::ID_W-1:0]       o_second_id;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [tbc_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [tbc_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    tracked_body_chooser #(.SLOTS(SLOTS)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_is_tracked(i_is_tracked),
        .i_body_id   (i_body_id),
        .i_body_depth(i_body_depth),
        .i_last_slot (i_last_slot),
        .o_strobe    (o_strobe),
        .o_first_id  (o_first_id),
        .o_second_id (o_second_id),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // chooser state as the bench sees it
    logic [tbc_pkg::MODE_W-1:0]  cur_mode = tbc_pkg::MODE_NONE;
    logic [tbc_pkg::DEPTH_W-1:0] cur_ceiling = tbc_pkg::CEILING_RESET;
    logic [tbc_pkg::DEPTH_W-1:0] near_depth [2] = '{tbc_pkg::CEILING_RESET,
                                                    tbc_pkg::CEILING_RESET};
    logic [tbc_pkg::ID_W-1:0]    near_id [2] = '{'0, '0};
    logic [tbc_pkg::ID_W-1:0]    frame_id [SLOTS] = '{default: '0};
    logic                        frame_trk [SLOTS] = '{default: 1'b0};
    logic [tbc_pkg::ID_W-1:0]    kept_id [2] = '{'0, '0};
    int unsigned                 frame_fill = 0;
    int unsigned                 frame_len = 0;

    t_pick_pair  pending_picks [$];
    int unsigned fails = 0;
    int unsigned words_sent = 0;
    int unsigned picks_checked = 0;
    int unsigned reg_writes = 0;
    int unsigned long_frames = 0;
    int unsigned frames_by_mode [MODES] = '{default: 0};
    bit          start_high = 1'b0;
    bit          cfg_high = 1'b0;
    bit          no_gaps = 1'b0;
    logic [tbc_pkg::ID_W-1:0] id_pool [POOL];

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic note_fail(input string msg);
        fails++;
        if (fails <= SHOW_FAILS)
            $display("%0t: %s", $realtime, msg);
    endtask

    // one slot word through the frame search; emits on the last slot
    task automatic choose_for_slot(input tbc_pkg::t_slot s, output bit emits,
                                   output t_pick_pair res);
        logic [tbc_pkg::ID_W-1:0] pick [2];
        bit found;
        emits = 1'b0;
        res = '0;
        if (frame_fill == 0) begin
            near_depth = '{cur_ceiling, cur_ceiling};
            near_id = '{'0, '0};
        end
        frame_len++;
        if (frame_fill < SLOTS) begin
            frame_id[frame_fill] = s.id;
            frame_trk[frame_fill] = s.tracked;
            frame_fill++;
            if (s.tracked) begin
                if (s.depth < near_depth[0]) begin
                    near_depth[1] = near_depth[0];
                    near_id[1] = near_id[0];
                    near_depth[0] = s.depth;
                    near_id[0] = s.id;
                end else if (s.depth < near_depth[1]) begin
                    near_depth[1] = s.depth;
                    near_id[1] = s.id;
                end
            end
        end
        if (!s.last)
            return;
        emits = 1'b1;
        frames_by_mode[cur_mode]++;
        if (frame_len > SLOTS)
            long_frames++;
        case (cur_mode)
            tbc_pkg::MODE_CLOSEST_ONE, tbc_pkg::MODE_CLOSEST_TWO: begin
                res.first = near_id[0];
                res.second = near_id[1];
            end
            tbc_pkg::MODE_STICKY_ONE, tbc_pkg::MODE_STICKY_TWO: begin
                pick = '{'0, '0};
                // stored IDs still present keep their place
                for (int p = 0; p < 2; p++) begin
                    found = 1'b0;
                    for (int q = 0; q < SLOTS; q++) begin
                        if (!found && frame_trk[q] && frame_id[q] == kept_id[p]) begin
                            pick[p] = frame_id[q];
                            found = 1'b1;
                        end
                    end
                end
                // then empty places fill in slot order
                for (int q = 0; q < SLOTS; q++) begin
                    if (!(pick[0] != 0 && pick[1] != 0) && frame_trk[q]) begin
                        if (pick[0] == 0 && frame_id[q] != pick[1])
                            pick[0] = frame_id[q];
                        else if (pick[1] == 0 && frame_id[q] != pick[0])
                            pick[1] = frame_id[q];
                    end
                end
                kept_id = pick;
                res.first = pick[0];
                res.second = pick[1];
            end
            default: res = '0;
        endcase
        if (cur_mode == tbc_pkg::MODE_CLOSEST_ONE || cur_mode == tbc_pkg::MODE_STICKY_ONE)
            res.second = '0;
        frame_trk = '{default: 1'b0};
        frame_fill = 0;
        frame_len = 0;
    endtask

    task automatic drop_start();
        if (start_high) begin
            start <= 1'b0;
            start_high = 1'b0;
        end
    endtask

    task automatic drop_cfg();
        if (cfg_high) begin
            i_cfg_valid <= 1'b0;
            cfg_high = 1'b0;
        end
    endtask

    task automatic send_slot(input tbc_pkg::t_slot s, input bit typed, input t_pick_pair want);
        bit emits;
        t_pick_pair got;
        start <= 1'b1;
        start_high = 1'b1;
        drop_cfg();
        i_is_tracked <= s.tracked;
        i_body_id <= s.id;
        i_body_depth <= s.depth;
        i_last_slot <= s.last;
        do @(posedge i_clk); while (busy !== 1'b0);
        words_sent++;
        choose_for_slot(s, emits, got);
        if (emits)
            pending_picks.push_back(typed ? want : got);
    endtask

    task automatic pause_sender();
        int unsigned r;
        int unsigned n;
        r = $urandom_range(0, 19);
        n = (r < 14) ? 0 : (r < 19) ? $urandom_range(1, 3) : $urandom_range(8, 40);
        if (no_gaps || n == 0)
            return;
        drop_start();
        i_is_tracked <= 1'($urandom);
        i_body_id <= $urandom;
        i_body_depth <= 16'($urandom);
        i_last_slot <= 1'($urandom);
        repeat (n) @(posedge i_clk);
    endtask

    // no frame in flight and every pair back before a register changes
    task automatic settle();
        drop_start();
        drop_cfg();
        while (pending_picks.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [tbc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tbc_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        cfg_high = 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        reg_writes++;
        case (idx)
            tbc_pkg::CFG_MODE:    cur_mode = data[tbc_pkg::MODE_W-1:0];
            tbc_pkg::CFG_CEILING: cur_ceiling = data;
            default:              ;
        endcase
    endtask

    function automatic t_plan_row crow(input logic [tbc_pkg::CFG_IDX_W-1:0] idx,
                                       input logic [tbc_pkg::CFG_DATA_W-1:0] data);
        return '{1'b1, idx, data, tbc_pkg::t_slot'('0), 1'b0, t_pick_pair'('0)};
    endfunction

    function automatic t_plan_row srow(input logic trk, input logic [tbc_pkg::ID_W-1:0] id,
                                       input logic [tbc_pkg::DEPTH_W-1:0] depth,
                                       input logic last);
        return '{1'b0, '0, '0, '{trk, id, depth, last}, 1'b0, t_pick_pair'('0)};
    endfunction

    function automatic t_plan_row trow(input logic trk, input logic [tbc_pkg::ID_W-1:0] id,
                                       input logic [tbc_pkg::DEPTH_W-1:0] depth,
                                       input logic [tbc_pkg::ID_W-1:0] first,
                                       input logic [tbc_pkg::ID_W-1:0] second);
        return '{1'b0, '0, '0, '{trk, id, depth, 1'b1}, 1'b1, '{first, second}};
    endfunction

    always @(posedge i_clk) begin
        t_pick_pair want;
        if (i_rst_n && o_strobe !== 1'b0) begin
            if (pending_picks.size() == 0) begin
                note_fail($sformatf("unexpected pair first=%h second=%h",
                                    o_first_id, o_second_id));
            end else begin
                want = pending_picks.pop_front();
                picks_checked++;
                if (o_first_id !== want.first)
                    note_fail($sformatf("first_id: expected %h, got %h",
                                        want.first, o_first_id));
                if (o_second_id !== want.second)
                    note_fail($sformatf("second_id: expected %h, got %h",
                                        want.second, o_second_id));
            end
        end
    end

    initial begin
        t_plan_row plan [PLAN_ROWS];
        tbc_pkg::t_slot s;
        int unsigned n_slots;
        int unsigned m;
        int unsigned r;
        int unsigned rand_words;
        int unsigned unused_frames;
        logic [tbc_pkg::DEPTH_W-1:0] tie_depth;
        logic [tbc_pkg::MODE_W-1:0] mode;

        plan = '{
            trow(1'b1, 32'h0000_0042, 16'd100, 32'h0, 32'h0),      // reset mode gives zeros
            crow(tbc_pkg::CFG_MODE, tbc_pkg::MODE_CLOSEST_TWO),
            srow(1'b1, 32'hFFFF_FFFF, 16'd0, 1'b0),
            srow(1'b1, 32'h0000_0001, 16'd32006, 1'b0),
            trow(1'b1, 32'h1234_5678, 16'd32007, 32'hFFFF_FFFF, 32'h0000_0001),
            srow(1'b1, 32'h0000_0011, 16'd500, 1'b0),               // equal depths
            srow(1'b1, 32'h0000_0022, 16'd500, 1'b0),
            trow(1'b1, 32'h0000_0033, 16'd500, 32'h0000_0011, 32'h0000_0022),
            crow(tbc_pkg::CFG_CEILING, 16'h0000),
            trow(1'b1, 32'hA5A5_A5A5, 16'd0, 32'h0, 32'h0),
            crow(tbc_pkg::CFG_CEILING, 16'hFFFF),
            crow(tbc_pkg::CFG_MODE, tbc_pkg::MODE_CLOSEST_ONE),
            srow(1'b1, 32'hAAAA_5555, 16'd65534, 1'b0),
            srow(1'b0, 32'hDEAD_BEEF, 16'd0, 1'b0),
            trow(1'b1, 32'h5555_AAAA, 16'd65535, 32'hAAAA_5555, 32'h0),
            srow(1'b0, 32'h0000_0060, 16'd0, 1'b0),                 // over-long frame
            srow(1'b0, 32'h0000_0061, 16'd0, 1'b0),
            srow(1'b0, 32'h0000_0062, 16'd0, 1'b0),
            srow(1'b0, 32'h0000_0063, 16'd0, 1'b0),
            srow(1'b0, 32'h0000_0064, 16'd0, 1'b0),
            srow(1'b1, 32'h0000_0066, 16'd9, 1'b0),
            trow(1'b1, 32'h0000_0077, 16'd0, 32'h0000_0066, 32'h0),
            crow(tbc_pkg::CFG_MODE, tbc_pkg::MODE_STICKY_TWO),
            srow(1'b1, 32'h0000_0010, 16'd1000, 1'b0),
            srow(1'b1, 32'h0000_0020, 16'd1000, 1'b0),
            trow(1'b1, 32'h0000_0030, 16'd1000, 32'h0000_0010, 32'h0000_0020),
            srow(1'b1, 32'h0000_0030, 16'd1000, 1'b0),              // 0x20 stays put
            trow(1'b1, 32'h0000_0020, 16'd1000, 32'h0000_0030, 32'h0000_0020),
            crow(tbc_pkg::CFG_MODE, tbc_pkg::MODE_STICKY_ONE),
            trow(1'b0, 32'h0000_0001, 16'd0, 32'h0, 32'h0),
            crow(tbc_pkg::CFG_MODE, {13'h1FFF, MODE_SPARE}),        // unused mode
            trow(1'b1, 32'h0000_0005, 16'd0, 32'h0, 32'h0)
        };
        for (int k = 0; k < POOL; k++)
            id_pool[k] = $urandom;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < PLAN_ROWS; k++) begin
            if (plan[k].is_cfg) begin
                settle();
                write_reg(plan[k].idx, plan[k].data);
            end else begin
                send_slot(plan[k].slot, plan[k].typed, plan[k].want);
                pause_sender();
            end
        end

        rand_words = 0;
        while (rand_words < RANDOM_WORDS) begin
            settle();
            if ($urandom_range(0, 9) != 0) begin
                m = $urandom_range(0, 11);
                mode = tbc_pkg::MODE_W'((m < 8) ? m : m - 7);
                write_reg(tbc_pkg::CFG_MODE,
                          {($urandom_range(0, 3) == 0) ? 13'($urandom) : 13'd0, mode});
            end
            if ($urandom_range(0, 9) < 7) begin
                case ($urandom_range(0, 9))
                    0:       write_reg(tbc_pkg::CFG_CEILING, 16'h0000);
                    1:       write_reg(tbc_pkg::CFG_CEILING, 16'hFFFF);
                    2:       write_reg(tbc_pkg::CFG_CEILING, tbc_pkg::CEILING_RESET);
                    3:       write_reg(tbc_pkg::CFG_CEILING, 16'($urandom_range(1, 64)));
                    default: write_reg(tbc_pkg::CFG_CEILING, 16'($urandom));
                endcase
            end
            if ($urandom_range(0, 19) == 0)
                write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, 16'($urandom));
            no_gaps = ($urandom_range(0, 3) == 0);

            repeat ($urandom_range(4, 16)) begin
                if ($urandom_range(0, 4) == 0)
                    id_pool[$urandom_range(0, POOL-1)] = $urandom;
                tie_depth = (cur_ceiling == 0) ? 16'($urandom)
                                               : 16'($urandom_range(0, int'(cur_ceiling) - 1));
                n_slots = ($urandom_range(0, 9) == 0) ? $urandom_range(SLOTS+1, SLOTS+3)
                                                      : $urandom_range(1, SLOTS);
                for (int k = 0; k < n_slots; k++) begin
                    s.tracked = ($urandom_range(0, 3) != 0);
                    r = $urandom_range(0, 19);
                    s.id = (r == 0) ? '0 : (r < 3) ? $urandom : id_pool[$urandom_range(0, POOL-1)];
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: s.depth = 16'($urandom);
                        4, 5, 6:    s.depth = (cur_ceiling == 0) ? '0
                                            : 16'($urandom_range(0, int'(cur_ceiling) - 1));
                        7:          s.depth = cur_ceiling - 16'($urandom_range(0, 1));
                        default:    s.depth = tie_depth;
                    endcase
                    s.last = (k == n_slots - 1);
                    send_slot(s, 1'b0, '0);
                    rand_words++;
                    pause_sender();
                end
            end
        end

        drop_start();
        drop_cfg();
        for (int k = 0; k < 500 && pending_picks.size() != 0; k++)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        while (pending_picks.size() != 0) begin
            void'(pending_picks.pop_front());
            note_fail("expected pair never strobed");
        end

        unused_frames = 0;
        for (int k = int'(tbc_pkg::MODE_STICKY_TWO) + 1; k < MODES; k++)
            unused_frames += frames_by_mode[k];

        $display("run: %0d slot words, %0d pairs checked, %0d over-long frames, %0d reg writes",
                 words_sent, picks_checked, long_frames, reg_writes);
        $display("frames by mode: none %0d, closest %0d/%0d, sticky %0d/%0d, unused %0d; fails %0d",
                 frames_by_mode[tbc_pkg::MODE_NONE], frames_by_mode[tbc_pkg::MODE_CLOSEST_ONE],
                 frames_by_mode[tbc_pkg::MODE_CLOSEST_TWO],
                 frames_by_mode[tbc_pkg::MODE_STICKY_ONE],
                 frames_by_mode[tbc_pkg::MODE_STICKY_TWO], unused_frames, fails);
        if (fails == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
